/* hdl/ffos_pkg.sv */
// shared types and constants for the force field obstacle steering unit
package ffos_pkg;

	// default sample width of one proximity sensor
	localparam int SAMPLE_WIDTH_DEF = 10;

	// field widths
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int DRIVE_W   = 11;
	localparam int NOISE_W   = 6;
	localparam int ANGLE_W   = 9;
	localparam int LIMIT_W   = 10;
	localparam int THRESH_W  = 10;

	// steering constants
	localparam int BIAS      = 10;
	localparam int ANGLE_LO  = 90;
	localparam int ANGLE_HI  = 270;
	localparam int GAIN_SHIFT = 6;

	// register reset values
	localparam int THRESH_RST = 5;
	localparam int LIMIT_RST  = 511;

	typedef logic [ANGLE_W-1:0]        angle_t;
	typedef logic [THRESH_W-1:0]       thresh_t;
	typedef logic [LIMIT_W-1:0]        limit_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;
	typedef logic signed [NOISE_W-1:0] noise_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NOISE_THRESHOLD = 2'd0,
		REG_DRIVE_LIMIT     = 2'd1,
		REG_VERTICAL_MODE   = 2'd2
	} cfg_reg_t;

	// heading bias control handed from the force stage to the drive stage
	typedef struct packed {
		logic active;
		logic up;
	} bias_t;

endpackage

/* hdl/ffos_force.sv */
// force stage: sample thresholding, force sums, per-wheel gain multiply and heading bias decision
module ffos_force #(
	parameter int SAMPLE_WIDTH = ffos_pkg::SAMPLE_WIDTH_DEF,
	localparam int SUM_W = SAMPLE_WIDTH + 3,
	localparam int S_W   = SAMPLE_WIDTH + 4,
	localparam int P_W   = S_W + ffos_pkg::DRIVE_W
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [4*SAMPLE_WIDTH-1:0]   prox_low,
	input  logic [4*SAMPLE_WIDTH-1:0]   prox_high,
	input  ffos_pkg::drive_t            desired_left,
	input  ffos_pkg::drive_t            desired_right,
	input  ffos_pkg::noise_t            noise_x,
	input  ffos_pkg::noise_t            noise_y,
	input  ffos_pkg::angle_t            tilt_angle,
	input  ffos_pkg::thresh_t           noise_threshold,
	input  logic                        vertical_mode,
	output logic signed [P_W-1:0]       prod_left_s2,
	output logic signed [P_W-1:0]       prod_right_s2,
	output ffos_pkg::drive_t            drive_left_s2,
	output ffos_pkg::drive_t            drive_right_s2,
	output ffos_pkg::bias_t             bias_s2
);

	localparam int CMP_W = (SAMPLE_WIDTH > ffos_pkg::THRESH_W) ?
		SAMPLE_WIDTH : ffos_pkg::THRESH_W;

	logic [SAMPLE_WIDTH-1:0] raw [8];
	logic [SAMPLE_WIDTH-1:0] p   [8];
	logic signed [SUM_W-1:0] x, y, nx, ny;
	logic signed [S_W-1:0]   s_add, s_sub, s_left, s_right;
	logic signed [P_W-1:0]   prod_left, prod_right;
	ffos_pkg::bias_t         bias;

	// unpack and threshold the samples
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			raw[i]   = prox_low[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
			raw[i+4] = prox_high[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
		end
		for (int i = 0; i < 8; i++) begin
			p[i] = (CMP_W'(raw[i]) < CMP_W'(noise_threshold)) ? '0 : raw[i];
		end
	end

	// weighted force sums with dither
	function automatic logic signed [SUM_W-1:0] ext(input logic [SAMPLE_WIDTH-1:0] v);
		return $signed({3'b000, v});
	endfunction

	assign nx = {{(SUM_W-ffos_pkg::NOISE_W){noise_x[ffos_pkg::NOISE_W-1]}}, noise_x};
	assign ny = {{(SUM_W-ffos_pkg::NOISE_W){noise_y[ffos_pkg::NOISE_W-1]}}, noise_y};

	assign x = -ext(p[0]) - ext(p[1] >> 1) + ext(p[3] >> 1) + ext(p[4])
		+ ext(p[5] >> 1) - ext(p[7] >> 1) + nx;
	assign y = ext(p[1] >> 1) + ext(p[2] >> 2) + ext(p[3] >> 1)
		- ext(p[5] >> 1) - ext(p[6] >> 2) - ext(p[7] >> 1) + ny;

	assign s_add = S_W'(x) + S_W'(y);
	assign s_sub = S_W'(x) - S_W'(y);

	// gain term picked by the sign of each drive
	assign s_left  = desired_left[ffos_pkg::DRIVE_W-1]  ? s_add : s_sub;
	assign s_right = desired_right[ffos_pkg::DRIVE_W-1] ? s_sub : s_add;

	assign prod_left  = P_W'(desired_left) * P_W'(s_left);
	assign prod_right = P_W'(desired_right) * P_W'(s_right);

	// tilt heading bias decision
	assign bias.active = vertical_mode && (desired_left != '0) && (desired_right != '0);
	assign bias.up     = (tilt_angle > ffos_pkg::angle_t'(ffos_pkg::ANGLE_LO)) &&
		(tilt_angle < ffos_pkg::angle_t'(ffos_pkg::ANGLE_HI));

	// stage register
	always_ff @(posedge clk) begin
		if (en) begin
			prod_left_s2   <= prod_left;
			prod_right_s2  <= prod_right;
			drive_left_s2  <= desired_left;
			drive_right_s2 <= desired_right;
			bias_s2        <= bias;
		end
	end

endmodule

/* hdl/ffos_drive.sv */
// drive stage: gain correction, heading bias and saturation
module ffos_drive #(
	parameter int SAMPLE_WIDTH = ffos_pkg::SAMPLE_WIDTH_DEF,
	localparam int P_W = SAMPLE_WIDTH + 4 + ffos_pkg::DRIVE_W
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [P_W-1:0]  prod_left_s2,
	input  logic signed [P_W-1:0]  prod_right_s2,
	input  ffos_pkg::drive_t       drive_left_s2,
	input  ffos_pkg::drive_t       drive_right_s2,
	input  ffos_pkg::bias_t        bias_s2,
	input  ffos_pkg::limit_t       drive_limit,
	output ffos_pkg::drive_t       left_drive,
	output ffos_pkg::drive_t       right_drive
);

	localparam int R_W = SAMPLE_WIDTH + 12;

	logic signed [R_W-1:0] term_l, term_r, d_l, d_r, sum_l, sum_r;
	logic signed [R_W-1:0] bias_l, bias_r, lim, v_l, v_r;
	ffos_pkg::drive_t      left_q, right_q;

	// floor divide by 64 and apply on the side of the drive sign
	assign term_l = R_W'(prod_left_s2 >>> ffos_pkg::GAIN_SHIFT);
	assign term_r = R_W'(prod_right_s2 >>> ffos_pkg::GAIN_SHIFT);
	assign d_l    = R_W'(drive_left_s2);
	assign d_r    = R_W'(drive_right_s2);
	assign sum_l  = drive_left_s2[ffos_pkg::DRIVE_W-1]  ? d_l - term_l : d_l + term_l;
	assign sum_r  = drive_right_s2[ffos_pkg::DRIVE_W-1] ? d_r - term_r : d_r + term_r;

	// heading bias
	always_comb begin
		bias_l = '0;
		bias_r = '0;
		if (bias_s2.active) begin
			bias_l = bias_s2.up ? R_W'(ffos_pkg::BIAS) : -R_W'(ffos_pkg::BIAS);
			bias_r = -bias_l;
		end
	end

	assign v_l = sum_l + bias_l;
	assign v_r = sum_r + bias_r;
	assign lim = $signed(R_W'(drive_limit));

	// saturation to plus or minus the limit
	function automatic ffos_pkg::drive_t sat(input logic signed [R_W-1:0] v,
		input logic signed [R_W-1:0] l);
		logic signed [R_W-1:0] r;
		r = v;
		if (v > l) r = l;
		else if (v < -l) r = -l;
		return ffos_pkg::DRIVE_W'(r);
	endfunction

	// result register
	always_ff @(posedge clk) begin
		if (en) begin
			left_q  <= sat(v_l, lim);
			right_q <= sat(v_r, lim);
		end
	end

	assign left_drive  = left_q;
	assign right_drive = right_q;

endmodule

/* hdl/force_field_obstacle_steering_unit.sv */
// top level of the force field obstacle steering unit
// throughput: one word per cycle; each stage holds its word only while downstream is full
// stages: input register, force sums and gain multiply, correction and saturation
// reset: all valid bits clear, registers return to threshold 5, limit 511, vertical off
module force_field_obstacle_steering_unit #(
	parameter int SAMPLE_WIDTH = ffos_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [4*SAMPLE_WIDTH-1:0]         prox_low,
	input  logic [4*SAMPLE_WIDTH-1:0]         prox_high,
	input  ffos_pkg::drive_t                  desired_left,
	input  ffos_pkg::drive_t                  desired_right,
	input  ffos_pkg::noise_t                  noise_x,
	input  ffos_pkg::noise_t                  noise_y,
	input  ffos_pkg::angle_t                  tilt_angle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ffos_pkg::drive_t                  left_drive,
	output ffos_pkg::drive_t                  right_drive,
	input  logic                              cfg_en,
	input  logic [ffos_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffos_pkg::CFG_W-1:0]        cfg_data
);

	localparam int P_W = SAMPLE_WIDTH + 4 + ffos_pkg::DRIVE_W;

	ffos_pkg::thresh_t  thresh_q;
	ffos_pkg::limit_t   limit_q;
	logic               vmode_q;

	logic               v_s1, v_s2, v_s3;
	logic               en1, en2, en3;

	logic [4*SAMPLE_WIDTH-1:0] prox_low_s1, prox_high_s1;
	ffos_pkg::drive_t   dl_s1, dr_s1;
	ffos_pkg::noise_t   nx_s1, ny_s1;
	ffos_pkg::angle_t   angle_s1;

	logic signed [P_W-1:0] prod_left_s2, prod_right_s2;
	ffos_pkg::drive_t   drive_left_s2, drive_right_s2;
	ffos_pkg::bias_t    bias_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ffos_pkg::thresh_t'(ffos_pkg::THRESH_RST);
			limit_q  <= ffos_pkg::limit_t'(ffos_pkg::LIMIT_RST);
			vmode_q  <= 1'b0;
		end else if (cfg_en) begin
			case (ffos_pkg::cfg_reg_t'(cfg_index))
				ffos_pkg::REG_NOISE_THRESHOLD: thresh_q <= cfg_data[ffos_pkg::THRESH_W-1:0];
				ffos_pkg::REG_DRIVE_LIMIT:     limit_q  <= cfg_data[ffos_pkg::LIMIT_W-1:0];
				ffos_pkg::REG_VERTICAL_MODE:   vmode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when it is empty or its word moves on
	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			prox_low_s1  <= prox_low;
			prox_high_s1 <= prox_high;
			dl_s1        <= desired_left;
			dr_s1        <= desired_right;
			nx_s1        <= noise_x;
			ny_s1        <= noise_y;
			angle_s1     <= tilt_angle;
		end
	end

	ffos_force #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_force (
		.clk             (clk),
		.en              (en2),
		.prox_low        (prox_low_s1),
		.prox_high       (prox_high_s1),
		.desired_left    (dl_s1),
		.desired_right   (dr_s1),
		.noise_x         (nx_s1),
		.noise_y         (ny_s1),
		.tilt_angle      (angle_s1),
		.noise_threshold (thresh_q),
		.vertical_mode   (vmode_q),
		.prod_left_s2    (prod_left_s2),
		.prod_right_s2   (prod_right_s2),
		.drive_left_s2   (drive_left_s2),
		.drive_right_s2  (drive_right_s2),
		.bias_s2         (bias_s2)
	);

	ffos_drive #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_drive (
		.clk            (clk),
		.en             (en3),
		.prod_left_s2   (prod_left_s2),
		.prod_right_s2  (prod_right_s2),
		.drive_left_s2  (drive_left_s2),
		.drive_right_s2 (drive_right_s2),
		.bias_s2        (bias_s2),
		.drive_limit    (limit_q),
		.left_drive     (left_drive),
		.right_drive    (right_drive)
	);

	// left result stays within the configured limit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(left_drive) <= $signed({1'b0, limit_q})) &&
		($signed(left_drive) >= -$signed({1'b0, limit_q})))
		else $error("left drive outside limit");

	// right result stays within the configured limit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(right_drive) <= $signed({1'b0, limit_q})) &&
		($signed(right_drive) >= -$signed({1'b0, limit_q})))
		else $error("right drive outside limit");

	// input stalls only when every stage is full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && !out_ready)
		else $error("input stalled with room in the pipeline");

	// a word in the middle stage reaches the output stage once it frees up
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en3 |=> v_s3)
		else $error("word lost between stages");

endmodule

/* tb/force_field_obstacle_steering_unit_test.sv */
// self-checking testbench for the force field obstacle steering unit
`timescale 1ns / 1ps

module force_field_obstacle_steering_unit_test;

	localparam int SW          = ffos_pkg::SAMPLE_WIDTH_DEF;
	localparam int RAND_PHASES = 7;
	localparam int PHASE_WORDS = 150;

	// index past the register list, a write there must be dropped
	localparam logic [ffos_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic [4*SW-1:0]  prox_low;
		logic [4*SW-1:0]  prox_high;
		ffos_pkg::drive_t desired_left;
		ffos_pkg::drive_t desired_right;
		ffos_pkg::noise_t noise_x;
		ffos_pkg::noise_t noise_y;
		ffos_pkg::angle_t tilt_angle;
	} sensor_word_t;

	typedef struct {
		ffos_pkg::drive_t left;
		ffos_pkg::drive_t right;
	} drives_t;

	typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [ffos_pkg::CFG_IDX_W-1:0]  idx;
		int                              val;
		sensor_word_t                    word;
		logic                            typed;
		drives_t                         want;
	} plan_row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic              in_valid      = 1'b0;
	logic              in_ready;
	logic [4*SW-1:0]   prox_low      = '0;
	logic [4*SW-1:0]   prox_high     = '0;
	ffos_pkg::drive_t  desired_left  = '0;
	ffos_pkg::drive_t  desired_right = '0;
	ffos_pkg::noise_t  noise_x       = '0;
	ffos_pkg::noise_t  noise_y       = '0;
	ffos_pkg::angle_t  tilt_angle    = '0;
	logic              out_valid;
	logic              out_ready     = 1'b0;
	ffos_pkg::drive_t  left_drive;
	ffos_pkg::drive_t  right_drive;
	logic              cfg_en        = 1'b0;
	logic [ffos_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ffos_pkg::CFG_W-1:0]     cfg_data  = '0;

	// hand-computed result riding along with the word on the bus
	logic             word_typed  = 1'b0;
	ffos_pkg::drive_t typed_left  = '0;
	ffos_pkg::drive_t typed_right = '0;

	// shadow copy of the configuration registers
	ffos_pkg::thresh_t thresh_q = ffos_pkg::thresh_t'(ffos_pkg::THRESH_RST);
	ffos_pkg::limit_t  limit_q  = ffos_pkg::limit_t'(ffos_pkg::LIMIT_RST);
	logic              vert_q   = 1'b0;

	logic      steady     = 1'b0;
	int        mismatches = 0;
	drives_t   pending_drives[$];
	plan_row_t stim_plan[$];

	force_field_obstacle_steering_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.prox_low      (prox_low),
		.prox_high     (prox_high),
		.desired_left  (desired_left),
		.desired_right (desired_right),
		.noise_x       (noise_x),
		.noise_y       (noise_y),
		.tilt_angle    (tilt_angle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_drive    (left_drive),
		.right_drive   (right_drive),
		.cfg_en        (cfg_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// scale one wheel: positive drives use the forward sum, negative the other
	function automatic int wheel_gain(input int d, input int s_up, input int s_down);
		if (d >= 0)
			return d + ((d * s_up) >>> ffos_pkg::GAIN_SHIFT);
		return d - ((d * s_down) >>> ffos_pkg::GAIN_SHIFT);
	endfunction

	// expected wheel drives for one sensor word under the current registers
	function automatic drives_t steer_predict(input sensor_word_t w);
		logic [8*SW-1:0] all_p;
		logic [SW-1:0]   raw;
		int              p[8];
		int              x, y, dl, dr, l, r, lim;
		drives_t         res;
		all_p = {w.prox_high, w.prox_low};
		for (int i = 0; i < 8; i++) begin
			raw  = all_p[i*SW +: SW];
			p[i] = (raw < thresh_q) ? 0 : int'(raw);
		end
		x = -p[0] - p[1] / 2 + p[3] / 2 + p[4] + p[5] / 2 - p[7] / 2 + int'(w.noise_x);
		y = p[1] / 2 + p[2] / 4 + p[3] / 2 - p[5] / 2 - p[6] / 4 - p[7] / 2
			+ int'(w.noise_y);
		dl = int'(w.desired_left);
		dr = int'(w.desired_right);
		l  = wheel_gain(dl, x - y, x + y);
		r  = wheel_gain(dr, x + y, x - y);
		// heading bias only when both wheels are asked to move
		if (vert_q && dl != 0 && dr != 0) begin
			if (w.tilt_angle > ffos_pkg::ANGLE_LO && w.tilt_angle < ffos_pkg::ANGLE_HI) begin
				l += ffos_pkg::BIAS;
				r -= ffos_pkg::BIAS;
			end else begin
				l -= ffos_pkg::BIAS;
				r += ffos_pkg::BIAS;
			end
		end
		lim = int'(limit_q);
		l = (l > lim) ? lim : ((l < -lim) ? -lim : l);
		r = (r > lim) ? lim : ((r < -lim) ? -lim : r);
		res.left  = ffos_pkg::drive_t'(l);
		res.right = ffos_pkg::drive_t'(r);
		return res;
	endfunction

	function automatic logic [SW-1:0] random_sample();
		int t;
		t = int'(thresh_q) + int'($urandom_range(0, 6)) - 3;
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return (t < 0) ? '0 : ((t > (1 << SW) - 1) ? '1 : SW'(t));
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic ffos_pkg::drive_t random_drive();
		case ($urandom_range(5))
			0: return '0;
			1: return $urandom_range(1) ? ffos_pkg::drive_t'(-1024) : ffos_pkg::drive_t'(1023);
			2: return ffos_pkg::drive_t'(int'($urandom_range(0, 16)) - 8);
			default: return ffos_pkg::drive_t'($urandom);
		endcase
	endfunction

	function automatic sensor_word_t random_word();
		sensor_word_t w;
		for (int i = 0; i < 4; i++) begin
			w.prox_low[i*SW +: SW]  = random_sample();
			w.prox_high[i*SW +: SW] = random_sample();
		end
		w.desired_left  = random_drive();
		w.desired_right = random_drive();
		w.noise_x       = ffos_pkg::noise_t'($urandom);
		w.noise_y       = ffos_pkg::noise_t'($urandom);
		// mostly legal angles, some near the bias edges, some past 359
		case ($urandom_range(9))
			0: w.tilt_angle = ffos_pkg::angle_t'($urandom_range(360, 511));
			1: w.tilt_angle = ffos_pkg::angle_t'(($urandom_range(1) ?
				ffos_pkg::ANGLE_LO : ffos_pkg::ANGLE_HI) + int'($urandom_range(0, 2)) - 1);
			default: w.tilt_angle = ffos_pkg::angle_t'($urandom_range(0, 359));
		endcase
		return w;
	endfunction

	function automatic void plan_word(input logic [4*SW-1:0] lo, input logic [4*SW-1:0] hi,
		input int dl, input int dr, input int nx, input int ny, input int ang,
		input logic typed, input int el, input int er);
		plan_row_t row;
		row.kind               = ROW_WORD;
		row.idx                = '0;
		row.val                = 0;
		row.word.prox_low      = lo;
		row.word.prox_high     = hi;
		row.word.desired_left  = ffos_pkg::drive_t'(dl);
		row.word.desired_right = ffos_pkg::drive_t'(dr);
		row.word.noise_x       = ffos_pkg::noise_t'(nx);
		row.word.noise_y       = ffos_pkg::noise_t'(ny);
		row.word.tilt_angle    = ffos_pkg::angle_t'(ang);
		row.typed              = typed;
		row.want.left          = ffos_pkg::drive_t'(el);
		row.want.right         = ffos_pkg::drive_t'(er);
		stim_plan.push_back(row);
	endfunction

	function automatic void plan_write(input logic [ffos_pkg::CFG_IDX_W-1:0] idx,
		input int val);
		plan_row_t row;
		row.kind  = ROW_WRITE;
		row.idx   = idx;
		row.val   = val;
		row.typed = 1'b0;
		stim_plan.push_back(row);
	endfunction

	// offer one word, with a random gap first, and hold it until taken
	task automatic present_word(input sensor_word_t w, input logic typed, input drives_t want);
		if (!steady) begin
			while ($urandom_range(99) < 27) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid      <= 1'b1;
		prox_low      <= w.prox_low;
		prox_high     <= w.prox_high;
		desired_left  <= w.desired_left;
		desired_right <= w.desired_right;
		noise_x       <= w.noise_x;
		noise_y       <= w.noise_y;
		tilt_angle    <= w.tilt_angle;
		word_typed    <= typed;
		typed_left    <= want.left;
		typed_right   <= want.right;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// stop sending and wait for every pending result to drain
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_drives.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [ffos_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= ffos_pkg::CFG_W'(val);
		@(posedge clk);
		cfg_en <= 1'b0;
		case (idx)
			ffos_pkg::REG_NOISE_THRESHOLD: thresh_q = ffos_pkg::thresh_t'(val);
			ffos_pkg::REG_DRIVE_LIMIT:     limit_q  = ffos_pkg::limit_t'(val);
			ffos_pkg::REG_VERTICAL_MODE:   vert_q   = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// result side back-pressure
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 27);

	// check outgoing words, then record the expectation of an incoming one
	always @(posedge clk) begin : watch
		drives_t      want;
		sensor_word_t arrived;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drives.size() == 0) begin
				flag_mismatch($sformatf("unexpected word left %0d right %0d",
					left_drive, right_drive));
			end else begin
				want = pending_drives.pop_front();
				if (left_drive !== want.left)
					flag_mismatch($sformatf("left_drive %0d, expected %0d",
						left_drive, want.left));
				if (right_drive !== want.right)
					flag_mismatch($sformatf("right_drive %0d, expected %0d",
						right_drive, want.right));
			end
		end
		if (arst_n && in_valid && in_ready) begin
			if (word_typed) begin
				want.left  = typed_left;
				want.right = typed_right;
			end else begin
				arrived.prox_low      = prox_low;
				arrived.prox_high     = prox_high;
				arrived.desired_left  = desired_left;
				arrived.desired_right = desired_right;
				arrived.noise_x       = noise_x;
				arrived.noise_y       = noise_y;
				arrived.tilt_angle    = tilt_angle;
				want = steer_predict(arrived);
			end
			pending_drives.push_back(want);
		end
	end

	// stimulus
	initial begin
		int      th, lm, vm;
		drives_t blank_drive;
		blank_drive.left  = '0;
		blank_drive.right = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: threshold 5, limit 511, no bias
		plan_word(40'd0, 40'd0, 0, 0, 0, 0, 0, 1'b1, 0, 0);
		plan_word(40'd0, 40'd0, 100, 100, 0, 0, 0, 1'b1, 100, 100);
		plan_word(40'd0, 40'd0, 1023, 1023, 0, 0, 0, 1'b1, 511, 511);
		plan_word(40'd0, 40'd0, -1024, -1024, 0, 0, 0, 1'b1, -511, -511);
		// sample just below and exactly at the threshold
		plan_word(40'd0, 40'd4, 200, -200, 0, 0, 0, 1'b1, 200, -200);
		plan_word(40'd0, 40'd5, 64, 64, 0, 0, 0, 1'b1, 69, 69);
		// single front and side sensor
		plan_word(40'd0, 40'd64, 64, 64, 0, 0, 0, 1'b1, 128, 128);
		plan_word(40'd64, 40'd0, 64, 64, 0, 0, 0, 1'b1, 0, 0);
		// dither at its 6-bit extremes
		plan_word(40'd0, 40'd0, 64, 64, -32, 31, 0, 1'b1, 1, 63);
		plan_word('1, '1, 1023, -1024, -32, -32, 0, 1'b0, 0, 0);
		plan_word(40'd0, '1, -1, 1, 31, -1, 359, 1'b0, 0, 0);
		plan_word(40'hAA_AAAA_AAAA, 40'h55_5555_5555, 512, -513, 5, -7, 200, 1'b0, 0, 0);
		// vertical bias around the angle edges
		plan_write(ffos_pkg::REG_VERTICAL_MODE, 1);
		plan_word(40'd0, 40'd0, 100, 100, 0, 0, 180, 1'b1, 110, 90);
		plan_word(40'd0, 40'd0, 100, 100, 0, 0, 90, 1'b1, 90, 110);
		plan_word(40'd0, 40'd0, 100, 100, 0, 0, 270, 1'b1, 90, 110);
		plan_word(40'd0, 40'd0, 100, 100, 0, 0, 91, 1'b1, 110, 90);
		plan_word(40'd0, 40'd0, 100, 100, 0, 0, 269, 1'b1, 110, 90);
		plan_word(40'd0, 40'd0, 100, 100, 0, 0, 511, 1'b1, 90, 110);
		plan_word(40'd0, 40'd0, 0, 100, 0, 0, 180, 1'b1, 0, 100);
		plan_word(40'd0, 40'd0, 100, -100, 0, 0, 180, 1'b1, 110, -110);
		// zero limit forces both drives to zero
		plan_write(ffos_pkg::REG_DRIVE_LIMIT, 0);
		plan_word(40'd0, 40'd0, 1023, -1024, 0, 0, 180, 1'b1, 0, 0);
		// widest limit, bias pushes past the 11-bit range
		plan_write(ffos_pkg::REG_DRIVE_LIMIT, 1023);
		plan_word(40'd0, 40'd0, 1023, 1023, 0, 0, 0, 1'b1, 1013, 1023);
		plan_word(40'd0, 40'd0, -1024, -1024, 0, 0, 180, 1'b1, -1014, -1023);
		plan_write(ffos_pkg::REG_NOISE_THRESHOLD, 1023);
		plan_word(40'hFF_FFFF_FFFE, '1, 300, -300, 0, 0, 100, 1'b0, 0, 0);
		plan_write(REG_SPARE, 0);
		plan_word(40'd0, 40'd64, 64, 64, 0, 0, 0, 1'b1, 54, 74);
		plan_write(ffos_pkg::REG_NOISE_THRESHOLD, 0);
		plan_write(ffos_pkg::REG_VERTICAL_MODE, 0);
		plan_word(40'd1, 40'd0, 64, 64, 0, 0, 0, 1'b1, 63, 63);

		foreach (stim_plan[k]) begin
			if (stim_plan[k].kind == ROW_WRITE) begin
				settle();
				write_reg(stim_plan[k].idx, stim_plan[k].val);
			end else begin
				present_word(stim_plan[k].word, stim_plan[k].typed, stim_plan[k].want);
			end
		end

		// random words under a new register setting per phase
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					th = ffos_pkg::THRESH_RST;
					lm = ffos_pkg::LIMIT_RST;
					vm = 0;
				end
				1: begin
					th = 0;
					lm = 1023;
					vm = 1;
				end
				2: begin
					th = 1023;
					lm = 1;
					vm = 0;
				end
				default: begin
					th = $urandom_range(1) ? $urandom_range(0, 40) : $urandom_range(0, 1023);
					lm = $urandom_range(0, 1023);
					vm = $urandom_range(1);
				end
			endcase
			settle();
			write_reg(ffos_pkg::REG_NOISE_THRESHOLD, th);
			write_reg(ffos_pkg::REG_DRIVE_LIMIT, lm);
			write_reg(ffos_pkg::REG_VERTICAL_MODE, vm);
			// one phase runs with no gaps and no stalls at all
			steady = (ph == 3);
			repeat (PHASE_WORDS)
				present_word(random_word(), 1'b0, blank_drive);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hdl/ffos_pkg.sv
hdl/ffos_force.sv
hdl/ffos_drive.sv
hdl/force_field_obstacle_steering_unit.sv
tb/force_field_obstacle_steering_unit_test.sv
